>>> rtl/core/subtractive_random_generator_assert.svh
// Assertion macros used by the checker file srg_chk.sv.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

// Property checked outside reset.
`define SRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/srg_pkg.sv
package srg_pkg;

  localparam int unsigned SeedBase    = 161803398;
  localparam int unsigned Modulus     = 1000000000;
  localparam int unsigned TableWords  = 55;
  localparam int unsigned FillStride  = 21;
  localparam int unsigned SecondStart = 31;
  localparam int unsigned WarmOffset  = 30;
  localparam int unsigned WarmPasses  = 4;
  // Last index whose warm-up partner lies above it
  localparam int unsigned WarmSplit   = TableWords - WarmOffset - 1;

  typedef logic [29:0] value_t;
  typedef logic [5:0]  idx_t;

  typedef struct packed {
    logic load_seed;
    logic seed_init;
    logic fill_step;
    logic warm_rd;
    logic draw_rd;
    logic draw_wr;
  } cmd_t;

  typedef struct packed {
    logic seed_neg;
    logic fill_last;
    logic warm_last;
  } sts_t;

  // a - b modulo the modulus, both operands already reduced
  function automatic value_t sub_mod(input value_t a, input value_t b);
    logic [30:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    return diff[30] ? value_t'(diff[29:0] + value_t'(Modulus)) : diff[29:0];
  endfunction

  // Step a pointer, wrapping from the last word to the first
  function automatic idx_t adv_ptr(input idx_t p);
    return (p >= idx_t'(TableWords)) ? idx_t'(1) : idx_t'(p + idx_t'(1));
  endfunction

endpackage

>>> rtl/core/srg_dp.sv
module srg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [31:0]  in_seed,
  input  srg_pkg::cmd_t       cmd,
  output srg_pkg::sts_t       sts,
  output srg_pkg::value_t     out_value
);
  import srg_pkg::*;

  value_t      mem_r [TableWords+1];
  logic [31:0] mag_r;
  value_t      cur_r;
  value_t      nxt_r;
  idx_t        slot_r;
  idx_t        fill_cnt_r;
  idx_t        wi_r;
  logic [1:0]  wpass_r;
  idx_t        fp_r;
  idx_t        sp_r;
  logic        pend_r;
  idx_t        wr_idx_r;
  value_t      rd_a_r;
  value_t      rd_b_r;
  value_t      out_value_r;

  logic        seed_gt;
  logic [31:0] seed_abs;
  value_t      seed_word;
  value_t      draw_d;
  idx_t        fp_adv;
  idx_t        sp_adv;
  idx_t        warm_j;
  logic [6:0]  slot_sum;
  logic        rd_en;
  idx_t        rd_addr_a;
  idx_t        rd_addr_b;
  logic        wr_en;
  idx_t        wr_addr;
  value_t      wr_data;

  // Starting word: |base - |seed|| reduced once, as it stays below twice the modulus
  assign seed_gt   = mag_r > 32'(SeedBase);
  assign seed_abs  = seed_gt ? (mag_r - 32'(SeedBase)) : (32'(SeedBase) - mag_r);
  assign seed_word = value_t'((seed_abs >= 32'(Modulus)) ? (seed_abs - 32'(Modulus))
                                                         : seed_abs);

  assign draw_d   = sub_mod(rd_a_r, rd_b_r);
  assign fp_adv   = adv_ptr(fp_r);
  assign sp_adv   = adv_ptr(sp_r);
  assign warm_j   = (wi_r <= idx_t'(WarmSplit)) ? idx_t'(wi_r + idx_t'(WarmOffset + 1))
                                                : idx_t'(wi_r - idx_t'(WarmSplit));
  assign slot_sum = {1'b0, slot_r} + 7'(FillStride);

  assign sts.seed_neg  = in_seed[31];
  assign sts.fill_last = fill_cnt_r == idx_t'(TableWords - 2);
  assign sts.warm_last = (wi_r == idx_t'(TableWords)) && (wpass_r == 2'(WarmPasses - 1));

  assign rd_en     = cmd.warm_rd | cmd.draw_rd;
  assign rd_addr_a = cmd.warm_rd ? wi_r   : fp_adv;
  assign rd_addr_b = cmd.warm_rd ? warm_j : sp_adv;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = fp_r;
    wr_data = draw_d;
    if (cmd.seed_init) begin
      wr_addr = idx_t'(TableWords);
      wr_data = seed_word;
    end else if (cmd.fill_step) begin
      wr_addr = slot_r;
      wr_data = nxt_r;
    end else if (pend_r) begin
      wr_addr = wr_idx_r;
    end else if (!cmd.draw_wr) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      mag_r <= in_seed[31] ? 32'(-in_seed) : 32'(in_seed);
    end
    if (cmd.seed_init) begin
      cur_r <= seed_word;
      nxt_r <= value_t'(1);
    end else if (cmd.fill_step) begin
      nxt_r <= sub_mod(cur_r, nxt_r);
      cur_r <= nxt_r;
    end
    if (cmd.warm_rd) begin
      wr_idx_r <= wi_r;
    end
    if (cmd.draw_wr) begin
      out_value_r <= draw_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= idx_t'(FillStride);
      fill_cnt_r <= '0;
      wi_r       <= idx_t'(1);
      wpass_r    <= '0;
      fp_r       <= '0;
      sp_r       <= idx_t'(SecondStart);
      pend_r     <= 1'b0;
    end else begin
      pend_r <= cmd.warm_rd;
      if (cmd.seed_init) begin
        slot_r     <= idx_t'(FillStride);
        fill_cnt_r <= '0;
        wi_r       <= idx_t'(1);
        wpass_r    <= '0;
        fp_r       <= '0;
        sp_r       <= idx_t'(SecondStart);
      end
      if (cmd.fill_step) begin
        slot_r     <= (slot_sum >= 7'(TableWords)) ? idx_t'(slot_sum - 7'(TableWords))
                                                   : slot_sum[5:0];
        fill_cnt_r <= fill_cnt_r + idx_t'(1);
      end
      if (cmd.warm_rd) begin
        if (wi_r == idx_t'(TableWords)) begin
          wi_r    <= idx_t'(1);
          wpass_r <= wpass_r + 2'd1;
        end else begin
          wi_r <= wi_r + idx_t'(1);
        end
      end
      if (cmd.draw_rd) begin
        fp_r <= fp_adv;
        sp_r <= sp_adv;
      end
    end
  end

  assign out_value = out_value_r;

endmodule

>>> rtl/core/srg_ctrl.sv
module srg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  srg_pkg::sts_t  sts,
  output srg_pkg::cmd_t  cmd
);
  import srg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SEED    = 6'b000010,
    ST_FILL    = 6'b000100,
    ST_WARM    = 6'b001000,
    ST_DRAW_RD = 6'b010000,
    ST_DRAW_WR = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_xfer;

  assign in_ready = state_r == ST_IDLE;
  assign in_xfer  = in_valid & in_ready;
  // Output register can take a result when empty or being drained
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.load_seed = 1'b1;
          state_nxt     = (sts.seed_neg || !started_r) ? ST_SEED : ST_DRAW_RD;
        end
      end
      ST_SEED: begin
        cmd.seed_init = 1'b1;
        state_nxt     = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_WARM;
        end
      end
      ST_WARM: begin
        cmd.warm_rd = 1'b1;
        if (sts.warm_last) begin
          started_nxt = 1'b1;
          state_nxt   = ST_DRAW_RD;
        end
      end
      ST_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_nxt   = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        // hold the read words until the output register frees up
        if (out_free) begin
          cmd.draw_wr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.draw_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/subtractive_random_generator.sv
// Subtractive lagged random number generator over a 55-word table.
// Input channel (in_valid/in_ready/in_seed): one transaction asks for one
// number. A negative seed, or the first transaction after reset, rebuilds the
// table from the seed before the draw; otherwise the seed is ignored.
// Output channel (out_valid/out_ready/out_value): one transaction per request,
// a value in 0..999999999, in request order.
// Sequence: an ordinary draw reads the table, then writes back the new word and
// loads the output register; a rebuild first runs a seed step, 54 fill writes
// and 220 warm-up steps. The controller takes one request at a time: a new
// request waits for the table read and write-back of the last draw.
// The table is one memory with two registered read ports and one write port;
// warm-up steps overlap the read of one step with the write of the one before.
// Reset: the table is left as is, the pointers return to 0 and 31 and the
// block is marked unseeded, so the next request always rebuilds.
// A stalled receiver holds out_value in the output register; the next request
// is still taken and its draw waits until the register frees up.
module subtractive_random_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_seed,
  output logic               out_valid,
  input  logic               out_ready,
  output srg_pkg::value_t    out_value
);
  import srg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seed   (in_seed),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_value)
  );

endmodule

>>> rtl/core/srg_chk.sv
`include "subtractive_random_generator_assert.svh"

module srg_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input srg_pkg::value_t out_value
);
  import srg_pkg::*;

  `SRG_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "reset state wrong")
  `SRG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value), "stalled result changed")
  `SRG_ASSERT(a_value_range, out_valid |-> out_value < value_t'(Modulus), "value out of range")
  `SRG_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request taken while busy")

endmodule

bind subtractive_random_generator srg_chk u_srg_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srg_pkg::*;

  typedef logic signed [31:0] seed_t;

  localparam int     QuietLimit = 4000;
  localparam int     TailCycles = 16;
  localparam longint ModulusL   = longint'(Modulus);

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  seed_t   in_seed   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  value_t  out_value;

  // Predicted generator state
  value_t  lag_words [1:TableWords];
  idx_t    lead_ptr  = '0;
  idx_t    trail_ptr = idx_t'(SecondStart);
  bit      seeded    = 1'b0;

  value_t  expected_values [$];
  int      fail_count     = 0;
  int      quiet_cycles   = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  subtractive_random_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_seed   (in_seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void reseed_table(input seed_t seed);
    longint mag;
    longint cur;
    longint nxt;
    longint diff;
    int     slot;
    int     i;
    int     pass;
    mag = longint'(seed);
    if (mag < 0) mag = -mag;
    cur = longint'(SeedBase) - mag;
    if (cur < 0) cur = -cur;
    cur = cur % ModulusL;
    lag_words[TableWords] = value_t'(cur);
    nxt = 1;
    for (i = 1; i < TableWords; i++) begin
      slot = (FillStride * i) % TableWords;
      lag_words[slot] = value_t'(nxt);
      nxt = cur - nxt;
      if (nxt < 0) nxt += ModulusL;
      cur = longint'(lag_words[slot]);
    end
    for (pass = 0; pass < WarmPasses; pass++) begin
      for (i = 1; i <= TableWords; i++) begin
        diff = longint'(lag_words[i])
             - longint'(lag_words[1 + (i + WarmOffset) % TableWords]);
        if (diff < 0) diff += ModulusL;
        lag_words[i] = value_t'(diff);
      end
    end
    lead_ptr  = '0;
    trail_ptr = idx_t'(SecondStart);
    seeded    = 1'b1;
  endfunction

  // Advance the predicted state by one request and return the number it yields
  function automatic value_t draw_value(input seed_t seed);
    longint diff;
    if (seed < 0 || !seeded) reseed_table(seed);
    lead_ptr  = (lead_ptr >= TableWords) ? idx_t'(1) : idx_t'(lead_ptr + 1);
    trail_ptr = (trail_ptr >= TableWords) ? idx_t'(1) : idx_t'(trail_ptr + 1);
    diff = longint'(lag_words[lead_ptr]) - longint'(lag_words[trail_ptr]);
    if (diff < 0) diff += ModulusL;
    lag_words[lead_ptr] = value_t'(diff);
    return value_t'(diff);
  endfunction

  function automatic void note_failure(input string what, input value_t want,
                                       input value_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    value_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        note_failure("value with no request outstanding", '0, out_value);
      end else begin
        want = expected_values.pop_front();
        if (out_value !== want) note_failure("value mismatch", want, out_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hold valid until the transaction completes, then idle now and then
  task automatic send_request(input seed_t seed);
    in_valid <= 1'b1;
    in_seed  <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_values.push_back(draw_value(seed));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4))
        @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  function automatic seed_t random_reseed();
    return seed_t'({1'b1, 31'($urandom)});
  endfunction

  function automatic seed_t random_draw_seed();
    return seed_t'({1'b0, 31'($urandom)});
  endfunction

  task automatic test_reseed_corners();
    // The first request after reset rebuilds the table even with a zero seed.
    // Seeds near the base constant give a zero or tiny starting word; the most
    // negative seed takes its full magnitude.
    seed_t corner_seeds [17] = '{
      32'sd0, 32'sh7fff_ffff, 32'sd1, -32'sd1, 32'sh5555_5555,
      -32'sd2147483647, 32'sh8000_0000, -32'sd161803398, -32'sd161803399,
      -32'sd161803397, -32'sd1161803398, -32'sd1161803399, -32'sd1000000000,
      32'shaaaa_aaaa, 32'sd12345, 32'sh7fff_ffff, 32'sd0
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corner_seeds[k]) send_request(corner_seeds[k]);
    wait_until_drained();
  endtask

  // The table must hold its state across a quiet spell on the input
  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    send_request(random_reseed());
    repeat (12) send_request(random_draw_seed());
    wait_until_drained();
    repeat (12) send_request(random_draw_seed());
    wait_until_drained();
  endtask

  // Runs of draws after a reseed; the longer runs wrap both pointers
  task automatic test_random_runs(input int idle_pct, input int stall_pct,
                                  input int item_count);
    int sent;
    int run_len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_count) begin
      send_request(random_reseed());
      run_len = ($urandom_range(3) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 40);
      repeat (run_len) send_request(random_draw_seed());
      sent += run_len + 1;
    end
    wait_until_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reseed_corners();
    test_pause_until_drained();
    test_random_runs(0, 0, 140);
    test_random_runs(45, 0, 140);
    test_random_runs(0, 45, 140);
    test_random_runs(23, 23, 140);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && expected_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/srg_pkg.sv
rtl/core/srg_dp.sv
rtl/core/srg_ctrl.sv
rtl/core/subtractive_random_generator.sv
rtl/core/srg_chk.sv
tb/tb_top.sv
